// ===== sv/cvwg_pkg.sv =====
// ----------------------------------------------------------------------------
// cvwg_pkg - shared types and constants for the CV waveform generator
// Segment codes, register indexes and per-stage payload structs.
// ----------------------------------------------------------------------------
package cvwg_pkg;

   localparam int unsigned CVWG_INDEX_BITS_DEF = 24;
   localparam int unsigned CVWG_IDX_W          = 32;   // widest point index
   localparam logic [15:0] CVWG_CODE_MAX       = 16'hFFFF;
   localparam int unsigned CVWG_FRAME_SHIFT    = 4;

   typedef enum logic [1:0] {
      SEG_INIT  = 2'd0,
      SEG_FWD   = 2'd1,
      SEG_REV   = 2'd2,
      SEG_FINAL = 2'd3
   } cvwg_seg_type;

   typedef enum logic [2:0] {
      CSR_END_CODES  = 3'd0,
      CSR_LIMIT1     = 3'd1,
      CSR_LIMIT2     = 3'd2,
      CSR_INIT_PTS   = 3'd3,
      CSR_CYCLE_PTS  = 3'd4,
      CSR_FINAL_PTS  = 3'd5,
      CSR_CYCLE_CNT  = 3'd6,
      CSR_FRAME_CTL  = 3'd7
   } cvwg_csr_type;

   // front stage: zero-extended index and sweep length
   typedef struct packed {
      logic [31:0]  idx;
      logic [39:0]  slen;
      logic         be;
   } cvwg_a_type;

   // cycle divider: rel / cycle length, 16 quotient bits
   typedef struct packed {
      logic [23:0]  rem;
      logic [15:0]  quo;
      logic [15:0]  low;
      logic [31:0]  pos;
      cvwg_seg_type seg;
      logic         be;
   } cvwg_d1_type;

   // interpolation operands
   typedef struct packed {
      logic [15:0]  from;
      logic [31:0]  pos;
      logic [15:0]  adiff;
      logic         neg;
      logic [23:0]  dvs;
      logic         ngt1;
      cvwg_seg_type seg;
      logic [15:0]  cyc;
      logic         be;
   } cvwg_c_type;

   // product
   typedef struct packed {
      logic [47:0]  mag;
      logic         neg;
      logic [23:0]  dvs;
      logic         ngt1;
      logic [15:0]  from;
      cvwg_seg_type seg;
      logic [15:0]  cyc;
      logic         be;
   } cvwg_m_type;

   // lerp divider: |num| / (n-1), 17 quotient bits plus saturation flag
   typedef struct packed {
      logic [23:0]  rem;
      logic [16:0]  quo;
      logic [16:0]  low;
      logic [23:0]  dvs;
      logic         sat;
      logic         neg;
      logic         ngt1;
      logic [15:0]  from;
      cvwg_seg_type seg;
      logic [15:0]  cyc;
      logic         be;
   } cvwg_d2_type;

endpackage

// ===== sv/cyclic_voltammetry_waveform_gen_core.sv =====
// ----------------------------------------------------------------------------
// cyclic_voltammetry_waveform_gen_core - CV triangle ramp point generator
// Maps a point index to a clamped DAC code and the 32-bit DAC frame.
// ----------------------------------------------------------------------------
// One point enters per clock while req_stall is low; its result passes 23
// register stages to the rsp_ ports, and the whole pipeline
// holds while a result beat waits under rsp_stall. The depth is set by
// two radix-2 dividers, two quotient bits per stage: the sweep position
// divider (index within the sweep part over the cycle length, 8 stages) and the
// interpolation divider (step times code span over points-1, 9 stages).
// Registers are meant to be written with no points in flight; csr_ready is
// always high.
module cyclic_voltammetry_waveform_gen_core #(
   parameter int unsigned INDEX_BITS = cvwg_pkg::CVWG_INDEX_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // point requests
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [INDEX_BITS-1:0] req_point_index,
   input  logic                  req_batch_end,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_dac_code,
   output logic [15:0]           rsp_frame_high,
   output logic [15:0]           rsp_frame_low,
   output logic [1:0]            rsp_segment,
   output logic [15:0]           rsp_cycle_number,
   output logic                  rsp_batch_end_out,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);
   import cvwg_pkg::*;

   localparam int unsigned D1_STAGES = 8;   // 16 bits, 2 per stage
   localparam int unsigned D2_STAGES = 9;   // 17 bits, 2 per stage
   localparam int unsigned D2_BITS   = 17;

   // ---------------- configuration registers ----------------
   logic [31:0] end_codes_ff;
   logic [15:0] limit1_ff, limit2_ff, cycle_cnt_ff;
   logic [23:0] init_pts_ff, cycle_pts_ff, final_pts_ff;
   logic [31:0] frame_ctl_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_codes_ff <= '0;
         limit1_ff    <= '0;
         limit2_ff    <= '0;
         init_pts_ff  <= '0;
         cycle_pts_ff <= '0;
         final_pts_ff <= '0;
         cycle_cnt_ff <= 16'd1;
         frame_ctl_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (cvwg_csr_type'(csr_index))
            CSR_END_CODES: end_codes_ff <= csr_data;
            CSR_LIMIT1:    limit1_ff    <= csr_data[15:0];
            CSR_LIMIT2:    limit2_ff    <= csr_data[15:0];
            CSR_INIT_PTS:  init_pts_ff  <= csr_data[23:0];
            CSR_CYCLE_PTS: cycle_pts_ff <= csr_data[23:0];
            CSR_FINAL_PTS: final_pts_ff <= csr_data[23:0];
            CSR_CYCLE_CNT: cycle_cnt_ff <= csr_data[15:0];
            CSR_FRAME_CTL: frame_ctl_ff <= csr_data;
            default:       ;
         endcase
      end
   end

   // whole pipeline advances together; it only holds when the output beat waits
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------- stage A: index capture, sweep length ----------------
   cvwg_a_type  a_ff, a_in;
   logic        a_vld_ff;
   logic [15:0] cycles;

   always_comb begin
      cycles  = (cycle_cnt_ff == 16'd0) ? 16'd1 : cycle_cnt_ff;
      a_in.idx  = CVWG_IDX_W'(req_point_index);
      a_in.slen = 40'(cycle_pts_ff) * 40'(cycles);
      a_in.be   = req_batch_end;
   end

   // ---------------- part select + cycle divider ----------------
   // d1[0] classifies the point; d1[1..8] each retire two quotient bits.
   cvwg_d1_type d1_ff [0:D1_STAGES];
   cvwg_d1_type d1_in [0:D1_STAGES];
   logic        d1_vld_ff [0:D1_STAGES];

   always_comb begin
      logic        is_init, in_sweep;
      logic [31:0] rel, rel2;
      cvwg_d1_type nxt;
      logic [24:0] t;
      is_init  = a_ff.idx < 32'(init_pts_ff);
      rel      = a_ff.idx - 32'(init_pts_ff);
      in_sweep = !is_init && (40'(rel) < a_ff.slen);
      rel2     = rel - a_ff.slen[31:0];
      // rel < cycle length * 2^16 inside the sweep, so rel[31:16] < cycle length
      d1_in[0].rem = 24'(rel[31:16]);
      d1_in[0].low = rel[15:0];
      d1_in[0].quo = '0;
      d1_in[0].pos = is_init ? a_ff.idx : rel2;
      d1_in[0].seg = is_init ? SEG_INIT : (in_sweep ? SEG_FWD : SEG_FINAL);
      d1_in[0].be  = a_ff.be;
      for (int s = 0; s < D1_STAGES; s++) begin
         nxt = d1_ff[s];
         for (int k = 0; k < 2; k++) begin
            t       = {nxt.rem, nxt.low[15]};
            nxt.low = {nxt.low[14:0], 1'b0};
            if (t >= {1'b0, cycle_pts_ff}) begin
               nxt.rem = 24'(t - {1'b0, cycle_pts_ff});
               nxt.quo = {nxt.quo[14:0], 1'b1};
            end else begin
               nxt.rem = t[23:0];
               nxt.quo = {nxt.quo[14:0], 1'b0};
            end
         end
         d1_in[s+1] = nxt;
      end
   end

   // ---------------- stage C: pick ramp endpoints ----------------
   cvwg_c_type c_ff, c_in;
   logic       c_vld_ff;

   always_comb begin
      logic [15:0]  to;
      logic [23:0]  n;
      logic [23:0]  half;
      logic [16:0]  diff;
      cvwg_d1_type  q;
      q    = d1_ff[D1_STAGES];
      half = {1'b0, cycle_pts_ff[23:1]};
      c_in.seg = q.seg;
      c_in.cyc = '0;
      c_in.be  = q.be;
      case (q.seg)
         SEG_INIT: begin
            c_in.from = end_codes_ff[31:16];
            to        = limit1_ff;
            c_in.pos  = q.pos;
            n         = init_pts_ff;
         end
         SEG_FWD, SEG_REV: begin
            c_in.cyc = q.quo;
            if (q.rem < half) begin
               c_in.seg  = SEG_FWD;
               c_in.from = limit1_ff;
               to        = limit2_ff;
               c_in.pos  = 32'(q.rem);
               n         = half;
            end else begin
               c_in.seg  = SEG_REV;
               c_in.from = limit2_ff;
               to        = limit1_ff;
               c_in.pos  = 32'(q.rem - half);
               n         = cycle_pts_ff - half;
            end
         end
         default: begin
            c_in.from = limit1_ff;
            to        = end_codes_ff[15:0];
            c_in.pos  = q.pos;
            n         = final_pts_ff;
         end
      endcase
      diff       = {1'b0, to} - {1'b0, c_in.from};
      c_in.neg   = diff[16];
      c_in.adiff = diff[16] ? 16'(-diff) : diff[15:0];
      c_in.ngt1  = n > 24'd1;
      c_in.dvs   = n - 24'd1;
   end

   // ---------------- stage M: |step| * |span| ----------------
   cvwg_m_type m_ff, m_in;
   logic       m_vld_ff;

   always_comb begin
      m_in.mag  = 48'(c_ff.pos) * 48'(c_ff.adiff);
      m_in.neg  = c_ff.neg;
      m_in.dvs  = c_ff.dvs;
      m_in.ngt1 = c_ff.ngt1;
      m_in.from = c_ff.from;
      m_in.seg  = c_ff.seg;
      m_in.cyc  = c_ff.cyc;
      m_in.be   = c_ff.be;
   end

   // ---------------- interpolation divider ----------------
   // A quotient of 2^17 or more clamps anyway, so only 17 bits are formed.
   cvwg_d2_type d2_ff [0:D2_STAGES];
   cvwg_d2_type d2_in [0:D2_STAGES];
   logic        d2_vld_ff [0:D2_STAGES];

   always_comb begin
      cvwg_d2_type nxt;
      logic [24:0] t;
      d2_in[0].sat  = m_ff.mag[47:17] >= 31'(m_ff.dvs);
      d2_in[0].rem  = m_ff.mag[40:17];
      d2_in[0].low  = m_ff.mag[16:0];
      d2_in[0].quo  = '0;
      d2_in[0].dvs  = m_ff.dvs;
      d2_in[0].neg  = m_ff.neg;
      d2_in[0].ngt1 = m_ff.ngt1;
      d2_in[0].from = m_ff.from;
      d2_in[0].seg  = m_ff.seg;
      d2_in[0].cyc  = m_ff.cyc;
      d2_in[0].be   = m_ff.be;
      for (int s = 0; s < D2_STAGES; s++) begin
         nxt = d2_ff[s];
         for (int k = 0; k < 2; k++) begin
            if (2 * s + k < D2_BITS) begin
               t       = {nxt.rem, nxt.low[16]};
               nxt.low = {nxt.low[15:0], 1'b0};
               if (t >= {1'b0, nxt.dvs}) begin
                  nxt.rem = 24'(t - {1'b0, nxt.dvs});
                  nxt.quo = {nxt.quo[15:0], 1'b1};
               end else begin
                  nxt.rem = t[23:0];
                  nxt.quo = {nxt.quo[15:0], 1'b0};
               end
            end
         end
         d2_in[s+1] = nxt;
      end
   end

   // ---------------- output stage: add, clamp, frame ----------------
   logic        rsp_valid_ff;
   logic [15:0] code_ff, fhi_ff, flo_ff, cyc_ff;
   logic [1:0]  seg_ff;
   logic        be_ff;
   logic [15:0] code_in;
   logic [31:0] frame_in;

   always_comb begin
      cvwg_d2_type  f;
      logic [18:0]  q;
      logic [18:0]  sum;
      f   = d2_ff[D2_STAGES];
      q   = f.ngt1 ? 19'(f.quo) : '0;
      sum = 19'(f.from) + (f.neg ? 19'(-q) : q);
      if (f.ngt1 && f.sat)
         code_in = f.neg ? 16'd0 : CVWG_CODE_MAX;
      else if (sum[18])
         code_in = 16'd0;
      else if (sum[17:16] != 2'd0)
         code_in = CVWG_CODE_MAX;
      else
         code_in = sum[15:0];
      frame_in = (frame_ctl_ff & ~(32'(CVWG_CODE_MAX) << CVWG_FRAME_SHIFT))
               | (32'(code_in) << CVWG_FRAME_SHIFT);
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= D1_STAGES; s++) d1_vld_ff[s] <= 1'b0;
         for (int s = 0; s <= D2_STAGES; s++) d2_vld_ff[s] <= 1'b0;
      end else if (en) begin
         a_vld_ff     <= req_valid;
         d1_vld_ff[0] <= a_vld_ff;
         for (int s = 1; s <= D1_STAGES; s++) d1_vld_ff[s] <= d1_vld_ff[s-1];
         c_vld_ff     <= d1_vld_ff[D1_STAGES];
         m_vld_ff     <= c_vld_ff;
         d2_vld_ff[0] <= m_vld_ff;
         for (int s = 1; s <= D2_STAGES; s++) d2_vld_ff[s] <= d2_vld_ff[s-1];
         rsp_valid_ff <= d2_vld_ff[D2_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         for (int s = 0; s <= D1_STAGES; s++) d1_ff[s] <= d1_in[s];
         c_ff <= c_in;
         m_ff <= m_in;
         for (int s = 0; s <= D2_STAGES; s++) d2_ff[s] <= d2_in[s];
         code_ff <= code_in;
         fhi_ff  <= frame_in[31:16];
         flo_ff  <= frame_in[15:0];
         seg_ff  <= d2_ff[D2_STAGES].seg;
         cyc_ff  <= d2_ff[D2_STAGES].cyc;
         be_ff   <= d2_ff[D2_STAGES].be;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dac_code      = code_ff;
   assign rsp_frame_high    = fhi_ff;
   assign rsp_frame_low     = flo_ff;
   assign rsp_segment       = seg_ff;
   assign rsp_cycle_number  = cyc_ff;
   assign rsp_batch_end_out = be_ff;

   // ---------------- assertions ----------------
   // an accepted beat lands in the front stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> a_vld_ff)
      else $error("accepted point lost at front stage");

   // the code field of the frame matches the code
   a_frame_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({rsp_frame_high[3:0], rsp_frame_low[15:4]} == rsp_dac_code))
      else $error("frame code field mismatch");

   // cycle number is zero outside the sweep
   a_cycle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_segment == SEG_INIT || rsp_segment == SEG_FINAL)
         |-> rsp_cycle_number == 16'd0)
      else $error("cycle number set outside sweep");

   // a held output keeps the pipeline frozen
   a_hold_frozen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(d2_vld_ff[D2_STAGES]) && $stable(a_vld_ff))
      else $error("pipeline moved while output held");

endmodule

// ===== tb/cyclic_voltammetry_waveform_gen_core_test.sv =====
// ----------------------------------------------------------------------------
// cyclic_voltammetry_waveform_gen_core_test - CV waveform generator testbench
// Drives point indexes through several register settings with random idle
// and stall, predicts each point's code, frame, part and cycle, and checks
// every result beat in order.
// ----------------------------------------------------------------------------
module cyclic_voltammetry_waveform_gen_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cvwg_pkg::*;

   // expected result of one point
   typedef struct {
      logic [15:0]  code;
      logic [15:0]  fhi;
      logic [15:0]  flo;
      cvwg_seg_type seg;
      logic [15:0]  cyc;
      logic         be;
   } point_result_type;

   // register shadow plus expected-result queue
   class point_scoreboard;
      logic [31:0] end_codes, frame_ctl;
      logic [15:0] lim1, lim2, ncyc;
      logic [23:0] n_init, n_cycle, n_final;
      point_result_type pending[$];
      int errors;

      function new();
         end_codes = 0; frame_ctl = 0; lim1 = 0; lim2 = 0; ncyc = 1;
         n_init = 0; n_cycle = 0; n_final = 0; errors = 0;
      endfunction

      function void write_reg(cvwg_csr_type r, logic [31:0] d);
         case (r)
            CSR_END_CODES: end_codes = d;
            CSR_LIMIT1:    lim1 = d[15:0];
            CSR_LIMIT2:    lim2 = d[15:0];
            CSR_INIT_PTS:  n_init = d[23:0];
            CSR_CYCLE_PTS: n_cycle = d[23:0];
            CSR_FINAL_PTS: n_final = d[23:0];
            CSR_CYCLE_CNT: ncyc = d[15:0];
            CSR_FRAME_CTL: frame_ctl = d;
            default:       ;
         endcase
      endfunction

      function logic [15:0] ramp(longint from, longint to, longint step, longint n);
         longint v;
         v = from;
         if (n > 1) v += (step * (to - from)) / (n - 1);
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
         return v[15:0];
      endfunction

      function void note_point(logic [23:0] pidx, logic be);
         point_result_type r;
         longint idx, cycles, slen, rel, pos, half;
         logic [31:0] frame;
         idx = pidx;
         cycles = (ncyc == 0) ? 1 : ncyc;
         slen = longint'(n_cycle) * cycles;
         r.cyc = 0;
         if (idx < n_init) begin
            r.seg = SEG_INIT;
            r.code = ramp(end_codes[31:16], lim1, idx, n_init);
         end else if (idx < n_init + slen) begin
            rel = idx - n_init;
            pos = rel % n_cycle;
            half = n_cycle / 2;
            r.cyc = 16'(rel / n_cycle);
            if (pos < half) begin
               r.seg = SEG_FWD;
               r.code = ramp(lim1, lim2, pos, half);
            end else begin
               r.seg = SEG_REV;
               r.code = ramp(lim2, lim1, pos - half, n_cycle - half);
            end
         end else begin
            r.seg = SEG_FINAL;
            r.code = ramp(lim1, end_codes[15:0], idx - n_init - slen, n_final);
         end
         frame = (frame_ctl & ~32'h000F_FFF0) | ({16'd0, r.code} << CVWG_FRAME_SHIFT);
         r.fhi = frame[31:16];
         r.flo = frame[15:0];
         r.be = be;
         pending.push_back(r);
      endfunction

      function void check_point(logic [15:0] code, logic [15:0] fhi, logic [15:0] flo,
                                logic [1:0] seg, logic [15:0] cyc, logic be);
         point_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat code=%h", $time, code);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (code !== e.code) begin
            $display("%0t: dac_code exp %h got %h", $time, e.code, code); errors++;
         end
         if (fhi !== e.fhi) begin
            $display("%0t: frame_high exp %h got %h", $time, e.fhi, fhi); errors++;
         end
         if (flo !== e.flo) begin
            $display("%0t: frame_low exp %h got %h", $time, e.flo, flo); errors++;
         end
         if (seg !== e.seg) begin
            $display("%0t: segment exp %0d got %0d", $time, e.seg, seg); errors++;
         end
         if (cyc !== e.cyc) begin
            $display("%0t: cycle_number exp %0d got %0d", $time, e.cyc, cyc); errors++;
         end
         if (be !== e.be) begin
            $display("%0t: batch_end_out exp %b got %b", $time, e.be, be); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [23:0] req_point_index = 0;
   logic        req_batch_end = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [15:0] rsp_dac_code, rsp_frame_high, rsp_frame_low, rsp_cycle_number;
   logic [1:0]  rsp_segment;
   logic        rsp_batch_end_out;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_data = 0;

   point_scoreboard sb = new();
   bit hold_off = 0;     // long receiver hold-off in progress
   bit stall_mode = 0;   // random stalling on/off

   always #2 clock = ~clock;

   cyclic_voltammetry_waveform_gen_core dut (.*);

   // accept points and results at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_point(req_point_index, req_batch_end);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_point(rsp_dac_code, rsp_frame_high, rsp_frame_low,
                        rsp_segment, rsp_cycle_number, rsp_batch_end_out);
   end

   // receiver stall pattern; a long hold-off forces backpressure to the input
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1;
            for (hold = 0; hold < 120; hold++) @(negedge clock);
            hold_off = 0;
            rsp_stall <= 0;
         end else begin
            rsp_stall <= stall_mode && ($urandom_range(0, 3) == 0);
         end
      end
   end

   task automatic write_reg(cvwg_csr_type r, logic [31:0] d);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= r;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(r, d);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // one beat; valid stays high across back-to-back beats
   task automatic send_point(logic [23:0] idx, logic be, bit last_in_burst);
      req_valid <= 1;
      req_point_index <= idx;
      req_batch_end <= be;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (last_in_burst) req_valid <= 0;
   endtask

   // idle gap; none half the time
   task automatic gap();
      int g;
      if ($urandom_range(0, 1) == 0) begin
         g = $urandom_range(1, 6);
         repeat (g) @(negedge clock);
      end
   endtask

   // wait for all expected beats, then the pipeline depth
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // pick an index spread over the parts of the current waveform, some past end
   function automatic logic [23:0] pick_index();
      longint span;
      span = longint'(sb.n_init) + longint'(sb.n_cycle) *
             ((sb.ncyc == 0) ? 1 : sb.ncyc) + sb.n_final;
      case ($urandom_range(0, 9))
         0: return 24'($urandom());
         1: return 24'hFFFFFF;
         default: begin
            if (span > 24'hFFFFF0) span = 24'hFFFFF0;
            return 24'($urandom_range(0, 32'(span) + 8));
         end
      endcase
   endfunction

   task automatic random_burst(int count);
      int k, b;
      k = 0;
      while (k < count) begin
         b = $urandom_range(1, 20);
         if (b > count - k) b = count - k;
         for (int j = 0; j < b; j++)
            send_point(pick_index(), 1'($urandom_range(0, 1)), j == b - 1);
         k += b;
         gap();
      end
   endtask

   task automatic random_setting();
      write_reg(CSR_END_CODES, $urandom());
      write_reg(CSR_LIMIT1, $urandom_range(0, 65535));
      write_reg(CSR_LIMIT2, $urandom_range(0, 65535));
      write_reg(CSR_INIT_PTS, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40));
      write_reg(CSR_CYCLE_PTS, $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 60));
      write_reg(CSR_FINAL_PTS, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40));
      write_reg(CSR_CYCLE_CNT, $urandom_range(0, 5) == 0 ? $urandom() : $urandom_range(0, 5));
      write_reg(CSR_FRAME_CTL, $urandom());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset values: everything lands in the final part at limit 1
      send_point(24'd0, 1'b0, 1);
      send_point(24'hFFFFFF, 1'b1, 1);
      drain();

      // directed: small waveform, all parts, zero cycles counted as one
      write_reg(CSR_END_CODES, 32'h1000_F000);
      write_reg(CSR_LIMIT1, 16'h0000);
      write_reg(CSR_LIMIT2, 16'hFFFF);
      write_reg(CSR_INIT_PTS, 24'd4);
      write_reg(CSR_CYCLE_PTS, 24'd6);
      write_reg(CSR_FINAL_PTS, 24'd3);
      write_reg(CSR_CYCLE_CNT, 16'd0);
      write_reg(CSR_FRAME_CTL, 32'hFFFF_FFFF);
      for (int i = 0; i < 16; i++) send_point(24'(i), i[0], i == 15);
      send_point(24'd40, 1'b0, 1);    // past end, extrapolated then clamped
      drain();

      // one-point cycle, one-point final part, empty initial part
      write_reg(CSR_CYCLE_PTS, 24'd1);
      write_reg(CSR_CYCLE_CNT, 16'd3);
      write_reg(CSR_INIT_PTS, 24'd0);
      write_reg(CSR_FINAL_PTS, 24'd1);
      write_reg(CSR_FRAME_CTL, 32'h0);
      for (int i = 0; i < 5; i++) send_point(24'(i), 1'b1, i == 4);
      drain();

      // maximum counts and cycles
      write_reg(CSR_INIT_PTS, 24'hFFFFFF);
      write_reg(CSR_CYCLE_PTS, 24'hFFFFFF);
      write_reg(CSR_FINAL_PTS, 24'hFFFFFF);
      write_reg(CSR_CYCLE_CNT, 16'hFFFF);
      send_point(24'hFFFFFE, 1'b0, 1);
      send_point(24'h7FFFFF, 1'b1, 1);
      drain();
      write_reg(CSR_INIT_PTS, 24'd2);
      send_point(24'hFFFFFF, 1'b0, 1);
      send_point(24'h800000, 1'b1, 1);
      drain();

      // random settings, random points, random stalling
      for (int ph = 0; ph < 16; ph++) begin
         random_setting();
         stall_mode = (ph % 3) != 0;
         if (ph == 5) hold_off = 1;
         random_burst(105);
         drain();
      end

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
